// File: rtl/sem_pkg.sv
// Shared types and constants for the streaming Sobel edge magnitude block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package sem_pkg;

    // Line store depth default and field widths
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 8;
    localparam int MAG_W         = 8;
    localparam int MAG_MAX       = 255;
    localparam int ROW_W         = 12;

    // Configuration port
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_REG_W  = 12;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_INDEX_W   = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Register reset values and smallest legal dimension
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int MIN_DIM       = 3;

    // One window column: top, middle and bottom row pixels
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } sem_col_t;

    // One line store entry: pixel two rows up and one row up
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } sem_lines_t;

    // Control that travels with a result through the kernel stages
    typedef struct packed {
        logic valid;
        logic interior;
        logic last;
    } sem_ctl_t;

endpackage

// File: rtl/sem_col_cell.sv
// One window column cell of the 3x3 shift chain.
// Depends on sem_pkg (sem_col_t).
module sem_col_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  sem_pkg::sem_col_t col_in,
    output sem_pkg::sem_col_t col_out
);

    sem_pkg::sem_col_t col_reg;

    // Take the neighbor's column on each shift, hold otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// File: rtl/sem_line_store.sv
// Dual line store: one memory holding the two previous rows per column.
// Entries above the fill mark have never been written and read as zero.
// Depends on sem_pkg (sem_lines_t).
module sem_line_store
#(
    parameter int DEPTH = sem_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output sem_pkg::sem_lines_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  sem_pkg::sem_lines_t wr_data
);

    sem_pkg::sem_lines_t mem [DEPTH];
    sem_pkg::sem_lines_t rd_data_reg;
    logic [AW:0]         fill_reg;

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Columns are written in order from zero, so the written entries form a prefix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (wr_en && ({1'b0, wr_addr} >= fill_reg))
        begin
            fill_reg <= {1'b0, wr_addr} + (AW+1)'(1);
        end
    end

    // Registered read; forward a write to the same entry, zero past the fill mark
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if ({1'b0, rd_addr} >= fill_reg)
            begin
                rd_data_reg <= '0;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sem_kernel.sv
// Sobel kernel: gradient stage and magnitude/saturation output register.
// Depends on sem_pkg (sem_col_t, sem_ctl_t, widths).
module sem_kernel
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  sem_pkg::sem_ctl_t             ctl_in,
    input  sem_pkg::sem_col_t             left,
    input  sem_pkg::sem_col_t             mid,
    input  sem_pkg::sem_col_t             right,
    output logic                          out_valid,
    output logic [sem_pkg::MAG_W-1:0]     magnitude,
    output logic                          last
);

    localparam int SUM_W = sem_pkg::PIX_W + 2;
    localparam int G_W   = SUM_W + 1;

    sem_pkg::sem_ctl_t        ctl_reg;
    logic signed [G_W-1:0]    gx_reg;
    logic signed [G_W-1:0]    gy_reg;
    logic signed [G_W-1:0]    gx_next;
    logic signed [G_W-1:0]    gy_next;
    logic [SUM_W-1:0]         lsum;
    logic [SUM_W-1:0]         rsum;
    logic [SUM_W-1:0]         tsum;
    logic [SUM_W-1:0]         bsum;
    logic signed [G_W-1:0]    gx_neg;
    logic signed [G_W-1:0]    gy_neg;
    logic [SUM_W-1:0]         ax;
    logic [SUM_W-1:0]         ay;
    logic [G_W-1:0]           mag_sum;
    logic [sem_pkg::MAG_W-1:0] mag_next;
    logic                     out_valid_reg;
    logic [sem_pkg::MAG_W-1:0] magnitude_reg;
    logic                     last_reg;

    // Weighted 1,2,1 sums of the outer columns and rows
    always_comb
    begin
        lsum = {2'b00, left.top} + {1'b0, left.mid, 1'b0} + {2'b00, left.bot};
        rsum = {2'b00, right.top} + {1'b0, right.mid, 1'b0} + {2'b00, right.bot};
        tsum = {2'b00, left.top} + {1'b0, mid.top, 1'b0} + {2'b00, right.top};
        bsum = {2'b00, left.bot} + {1'b0, mid.bot, 1'b0} + {2'b00, right.bot};
        gx_next = $signed({1'b0, rsum}) - $signed({1'b0, lsum});
        gy_next = $signed({1'b0, tsum}) - $signed({1'b0, bsum});
    end

    // Gradient stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
    end

    // Absolute values, sum and saturate; border positions give zero
    always_comb
    begin
        gx_neg  = -gx_reg;
        gy_neg  = -gy_reg;
        ax      = gx_reg[G_W-1] ? gx_neg[SUM_W-1:0] : gx_reg[SUM_W-1:0];
        ay      = gy_reg[G_W-1] ? gy_neg[SUM_W-1:0] : gy_reg[SUM_W-1:0];
        mag_sum = {1'b0, ax} + {1'b0, ay};
        if (!ctl_reg.interior)
        begin
            mag_next = '0;
        end
        else if (mag_sum > G_W'(sem_pkg::MAG_MAX))
        begin
            mag_next = sem_pkg::MAG_W'(sem_pkg::MAG_MAX);
        end
        else
        begin
            mag_next = mag_sum[sem_pkg::MAG_W-1:0];
        end
    end

    // Output register; holds while the consumer stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            magnitude_reg <= mag_next;
            last_reg      <= ctl_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = magnitude_reg;
    assign last      = last_reg;

endmodule

// File: rtl/sobel_edge_magnitude_stream.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Depends on sem_pkg, sem_line_store, sem_col_cell and sem_kernel.
//
// Feed 8-bit grayscale pixels in raster order; each result is |Gx|+|Gy| of the
// pixel's 3x3 neighborhood, saturated to 255, and 0 on the image border. A
// result appears image_width+1 words after its pixel, so after the last pixel
// send image_width+1 flush words (kind=1) to drain the image; the final result
// carries last=1 and the next image may start with the following word. Flush
// words sent before the image is complete are dropped, and pixels sent after
// it act as flush words. The block takes one word per clock: a word enters a
// three-stage pipeline (line store read, window shift and gradient, magnitude
// register), with one single-ported-write memory holding the two previous
// rows. Input stalls only while a result waits in the output register and the
// consumer stalls. The line store needs no clearing pass: a fill mark makes
// entries that were never written since reset read as zero.
// Write image_width/image_height only while no result is pending.
module sobel_edge_magnitude_stream
#(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sem_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [sem_pkg::PIX_W-1:0]          pixel,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sem_pkg::MAG_W-1:0]          magnitude,
    output logic                               last
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int EW0     = $clog2(MAX_WIDTH + 1);
    localparam int EW      = (EW0 > sem_pkg::WIDTH_REG_W) ? EW0 : sem_pkg::WIDTH_REG_W;
    localparam int RW      = sem_pkg::ROW_W;
    localparam int RESET_W = (sem_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : sem_pkg::WIDTH_RESET;

    // Effective dimensions and their bounds
    logic [EW-1:0] eff_w_reg;
    logic [EW-1:0] w_m1_reg;
    logic [EW-1:0] w_m2_reg;
    logic [RW-1:0] eff_h_reg;
    logic [RW-1:0] h_m1_reg;
    logic [RW-1:0] h_m2_reg;
    logic [EW-1:0] cfg_w;
    logic [RW-1:0] cfg_h;

    // Position counters
    logic [CW-1:0] in_col_reg;
    logic [CW-1:0] in_col_next;
    logic [RW-1:0] in_row_reg;
    logic [RW-1:0] in_row_next;
    logic [CW-1:0] out_col_reg;
    logic [CW-1:0] out_col_next;
    logic [RW-1:0] out_row_reg;
    logic [RW-1:0] out_row_next;

    // Front-end decode of the incoming word
    logic          hold;
    logic          adv;
    logic          accept;
    logic          in_wrap;
    logic [CW-1:0] col0;
    logic [RW-1:0] row0;
    logic          in_image;
    logic          do_shift;
    logic          do_emit;
    logic [EW-1:0] col_inc;
    logic          out_wrap;
    logic [CW-1:0] ocol;
    logic [RW-1:0] orow;
    logic [EW-1:0] ocol_inc;
    logic          pos_interior;
    logic          pos_last;

    // Window stage
    logic                s1_shift_reg;
    sem_pkg::sem_ctl_t   s1_ctl_reg;
    logic [sem_pkg::PIX_W-1:0] s1_px_reg;
    logic [CW-1:0]       s1_idx_reg;
    sem_pkg::sem_lines_t lines_rd;
    sem_pkg::sem_lines_t lines_wr;
    sem_pkg::sem_col_t   new_col;
    sem_pkg::sem_col_t   c0;
    sem_pkg::sem_col_t   c1;
    sem_pkg::sem_col_t   c2;
    sem_pkg::sem_col_t   win_l;
    sem_pkg::sem_col_t   win_m;
    sem_pkg::sem_col_t   win_r;
    logic                win_shift;

    // Clamp configuration data to legal dimensions
    always_comb
    begin
        cfg_w = EW'(cfg_data[sem_pkg::WIDTH_REG_W-1:0]);
        if (cfg_w < EW'(sem_pkg::MIN_DIM))
        begin
            cfg_w = EW'(sem_pkg::MIN_DIM);
        end
        else if (cfg_w > EW'(MAX_WIDTH))
        begin
            cfg_w = EW'(MAX_WIDTH);
        end
        cfg_h = cfg_data[sem_pkg::HEIGHT_REG_W-1:0];
        if (cfg_h < RW'(sem_pkg::MIN_DIM))
        begin
            cfg_h = RW'(sem_pkg::MIN_DIM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= EW'(RESET_W);
            w_m1_reg  <= EW'(RESET_W - 1);
            w_m2_reg  <= EW'(RESET_W - 2);
            eff_h_reg <= RW'(sem_pkg::HEIGHT_RESET);
            h_m1_reg  <= RW'(sem_pkg::HEIGHT_RESET - 1);
            h_m2_reg  <= RW'(sem_pkg::HEIGHT_RESET - 2);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sem_pkg::CFG_IMAGE_WIDTH:
                begin
                    eff_w_reg <= cfg_w;
                    w_m1_reg  <= cfg_w - EW'(1);
                    w_m2_reg  <= cfg_w - EW'(2);
                end
                sem_pkg::CFG_IMAGE_HEIGHT:
                begin
                    eff_h_reg <= cfg_h;
                    h_m1_reg  <= cfg_h - RW'(1);
                    h_m2_reg  <= cfg_h - RW'(2);
                end
            endcase
        end
    end

    // Stall everything while a result waits and the consumer stalls
    assign hold     = out_valid && out_stall;
    assign adv      = !hold;
    assign in_stall = hold;
    assign accept   = in_valid && !hold;

    // Decode the word: window shift, result emission and counter advance
    always_comb
    begin
        in_wrap  = EW'(in_col_reg) >= eff_w_reg;
        col0     = in_wrap ? '0 : in_col_reg;
        row0     = in_wrap ? RW'(in_row_reg + RW'(1)) : in_row_reg;
        in_image = row0 < eff_h_reg;
        do_shift = in_image && !kind;
        if (in_image)
        begin
            do_emit = !kind && ((row0 >= RW'(2)) || ((row0 == RW'(1)) && (col0 != '0)));
        end
        else
        begin
            do_emit = 1'b1;
        end
        col_inc = EW'(col0) + EW'(1);

        out_wrap     = EW'(out_col_reg) >= eff_w_reg;
        ocol         = out_wrap ? '0 : out_col_reg;
        orow         = out_wrap ? RW'(out_row_reg + RW'(1)) : out_row_reg;
        ocol_inc     = EW'(ocol) + EW'(1);
        pos_interior = (orow >= RW'(1)) && (orow <= h_m2_reg)
                       && (ocol != '0) && (EW'(ocol) <= w_m2_reg);
        pos_last     = (orow >= h_m1_reg) && (EW'(ocol) >= w_m1_reg);

        in_col_next  = col0;
        in_row_next  = row0;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (do_shift)
        begin
            if (col_inc >= eff_w_reg)
            begin
                in_col_next = '0;
                in_row_next = RW'(row0 + RW'(1));
            end
            else
            begin
                in_col_next = col_inc[CW-1:0];
            end
        end
        if (do_emit)
        begin
            if (pos_last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (ocol_inc >= eff_w_reg)
            begin
                out_col_next = '0;
                out_row_next = RW'(orow + RW'(1));
            end
            else
            begin
                out_col_next = ocol_inc[CW-1:0];
                out_row_next = orow;
            end
        end
    end

    // Advance counters on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Window stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_shift_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else if (adv)
        begin
            s1_shift_reg        <= accept && do_shift;
            s1_ctl_reg.valid    <= accept && do_emit;
            s1_ctl_reg.interior <= pos_interior;
            s1_ctl_reg.last     <= pos_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg  <= pixel;
            s1_idx_reg <= col0;
        end
    end

    // Line store: read on acceptance, write back from the window stage registers
    assign lines_wr.upper  = lines_rd.middle;
    assign lines_wr.middle = s1_px_reg;

    sem_line_store
    #(
        .DEPTH   (MAX_WIDTH),
        .AW      (CW)
    )
    u_line_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && do_shift),
        .rd_addr (col0),
        .rd_data (lines_rd),
        .wr_en   (adv && s1_shift_reg),
        .wr_addr (s1_idx_reg),
        .wr_data (lines_wr)
    );

    // Chain of column cells: new column enters on the right
    assign new_col.top = lines_rd.upper;
    assign new_col.mid = lines_rd.middle;
    assign new_col.bot = s1_px_reg;
    assign win_shift   = adv && s1_shift_reg;

    sem_col_cell u_cell_left
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (win_shift),
        .col_in   (c1),
        .col_out  (c0)
    );

    sem_col_cell u_cell_mid
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (win_shift),
        .col_in   (c2),
        .col_out  (c1)
    );

    sem_col_cell u_cell_right
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (win_shift),
        .col_in   (new_col),
        .col_out  (c2)
    );

    // Present the window as it stands after this word's shift
    always_comb
    begin
        if (s1_shift_reg)
        begin
            win_l = c1;
            win_m = c2;
            win_r = new_col;
        end
        else
        begin
            win_l = c0;
            win_m = c1;
            win_r = c2;
        end
    end

    sem_kernel u_kernel
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_in    (s1_ctl_reg),
        .left      (win_l),
        .mid       (win_m),
        .right     (win_r),
        .out_valid (out_valid),
        .magnitude (magnitude),
        .last      (last)
    );

    // The final result of an image always lies on the border
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (magnitude == '0))
    else $error("last result with nonzero magnitude");

    // A stalled pipeline must not move the window
    assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> $stable({c0, c1, c2}))
    else $error("window shifted while output stalled");

    // A stalled pipeline must not lose its pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold && s1_ctl_reg.valid) |=> s1_ctl_reg.valid)
    else $error("window stage result dropped during stall");

endmodule

// File: sim/tb_sobel_edge_magnitude_stream.sv
// Self-checking testbench for sobel_edge_magnitude_stream: random-gap pixel driver,
// stalling result monitor and an in-order predictor of the edge magnitudes.
// Depends on sem_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_stream;

    // Widths and register constants taken from the package
    localparam int PIX_W        = sem_pkg::PIX_W;
    localparam int MAG_W        = sem_pkg::MAG_W;
    localparam int MAG_MAX      = sem_pkg::MAG_MAX;
    localparam int ROW_W        = sem_pkg::ROW_W;
    localparam int WIDTH_REG_W  = sem_pkg::WIDTH_REG_W;
    localparam int HEIGHT_REG_W = sem_pkg::HEIGHT_REG_W;
    localparam int CFG_DATA_W   = sem_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W  = sem_pkg::CFG_INDEX_W;
    localparam int MIN_DIM      = sem_pkg::MIN_DIM;

    localparam int LINE_DEPTH     = sem_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_PIXELS  = 800;
    localparam int WIDE_PIXELS    = 120;
    localparam int EXTREME_PIXELS = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 4000000;
    localparam int MAX_REPORTS    = 100;

    // Word kinds on the input channel
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Pixel patterns for generated frames
    localparam int PAT_NOISE = 0;
    localparam int PAT_RAMP  = 1;
    localparam int PAT_STEP  = 2;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pix;
    } pixel_word_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             is_last;
    } grad_result_t;

    // Clock, reset and block ports
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = sem_pkg::CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic                   kind      = KIND_PIXEL;
    logic [PIX_W-1:0]       pixel     = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [MAG_W-1:0]       magnitude;
    logic                   last;

    // Predictor state: registers, line stores, window and position counters
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_REG_W'(sem_pkg::WIDTH_RESET);
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_REG_W'(sem_pkg::HEIGHT_RESET);
    logic [PIX_W-1:0]        above_line [LINE_DEPTH];
    logic [PIX_W-1:0]        prev_line  [LINE_DEPTH];
    logic [PIX_W-1:0]        win [3][3];
    logic [10:0]             col_in, col_out;
    logic [ROW_W-1:0]        row_in, row_out;

    // Stimulus backlog, expected magnitudes and bookkeeping
    pixel_word_t  word_backlog [$];
    grad_result_t mag_pending [$];
    pixel_word_t  next_word;
    grad_result_t head_result;
    bit           src_steady  = 1'b0;
    bit           sink_steady = 1'b0;
    int           gap_left    = 0;
    int           stall_left  = 0;
    int           errors      = 0;
    int           cycle_count = 0;
    int           words_accepted  = 0;
    int           results_checked = 0;
    int           frames_closed   = 0;
    int           pixels_sent     = 0;
    int           reg_writes      = 0;

    sobel_edge_magnitude_stream DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .magnitude (magnitude),
        .last      (last)
    );

    always #10 clk = ~clk;

    // Mismatch reporting: one line each, printing capped, counting not
    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic int clamp_width(logic [WIDTH_REG_W-1:0] r);
        if (r < MIN_DIM)
            return MIN_DIM;
        if (r > LINE_DEPTH)
            return LINE_DEPTH;
        return r;
    endfunction

    function automatic int clamp_height(logic [HEIGHT_REG_W-1:0] r);
        return (r < MIN_DIM) ? MIN_DIM : r;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Advance the predictor by one accepted word; queue the magnitude it releases
    task automatic sobel_predict(input logic word_kind, input logic [PIX_W-1:0] word_pix);
        int fw, fh, idx, gx, gy, sum;
        int p00, p01, p02, p10, p12, p20, p21, p22;
        logic emit;
        grad_result_t res;
        fw = clamp_width(width_reg);
        fh = clamp_height(height_reg);
        if (col_in >= fw)
        begin
            col_in = 0;
            row_in++;
        end
        if (row_in < fh)
        begin
            // drop flush words until the image is complete
            if (word_kind == KIND_FLUSH)
                return;
            idx = (col_in < LINE_DEPTH) ? col_in : LINE_DEPTH - 1;
            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = above_line[idx];
            win[1][2] = prev_line[idx];
            win[2][2] = word_pix;
            above_line[idx] = prev_line[idx];
            prev_line[idx]  = word_pix;
            emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
            col_in++;
            if (col_in >= fw)
            begin
                col_in = 0;
                row_in++;
            end
        end
        else
            emit = 1'b1;
        if (!emit)
            return;

        if (col_out >= fw)
        begin
            col_out = 0;
            row_out++;
        end
        // interior pixels get the gradient sum, border pixels zero
        if (row_out >= 1 && row_out <= fh - 2 && col_out >= 1 && col_out <= fw - 2)
        begin
            p00 = win[0][0]; p01 = win[0][1]; p02 = win[0][2];
            p10 = win[1][0];                  p12 = win[1][2];
            p20 = win[2][0]; p21 = win[2][1]; p22 = win[2][2];
            gx  = (p02 + 2 * p12 + p22) - (p00 + 2 * p10 + p20);
            gy  = (p00 + 2 * p01 + p02) - (p20 + 2 * p21 + p22);
            sum = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
            res.mag = (sum > MAG_MAX) ? MAG_W'(MAG_MAX) : MAG_W'(sum);
        end
        else
            res.mag = '0;
        res.is_last = (row_out >= fh - 1) && (col_out >= fw - 1);
        mag_pending.push_back(res);

        // the final result restarts all four counters
        if (res.is_last)
        begin
            col_in  = 0;
            row_in  = 0;
            col_out = 0;
            row_out = 0;
        end
        else
        begin
            col_out++;
            if (col_out >= fw)
            begin
                col_out = 0;
                row_out++;
            end
        end
    endtask

    // Input driver: account for the accepted word, then load the next one after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind     <= KIND_PIXEL;
            pixel    <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sobel_predict(kind, pixel);
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_backlog.size() > 0)
                begin
                    next_word = word_backlog.pop_front();
                    in_valid <= 1'b1;
                    kind     <= next_word.kind;
                    pixel    <= next_word.pix;
                    gap_left = pick_gap(src_steady);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: random stall bursts unless the sink runs steady
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!sink_steady && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap(1'b0);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Result monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (mag_pending.size() == 0)
                report_mismatch("unexpected result magnitude", magnitude, -1);
            else
            begin
                head_result = mag_pending.pop_front();
                if (magnitude !== head_result.mag)
                    report_mismatch("magnitude", magnitude, head_result.mag);
                if (last !== head_result.is_last)
                    report_mismatch("last", last, head_result.is_last);
                if (head_result.is_last)
                    frames_closed++;
                results_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, mag_pending.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_word(logic word_kind, logic [PIX_W-1:0] word_pix);
        pixel_word_t w;
        w.kind = word_kind;
        w.pix  = word_pix;
        word_backlog.push_back(w);
    endtask

    // Wait until every word is taken and every result is back, then let the pipe settle
    task automatic wait_quiet();
        while (word_backlog.size() != 0 || in_valid || mag_pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == sem_pkg::CFG_IMAGE_WIDTH)
            width_reg = data[WIDTH_REG_W-1:0];
        else
            height_reg = data[HEIGHT_REG_W-1:0];
        reg_writes++;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] wdat, logic [CFG_DATA_W-1:0] hdat);
        wait_quiet();
        write_reg(sem_pkg::CFG_IMAGE_WIDTH, wdat);
        write_reg(sem_pkg::CFG_IMAGE_HEIGHT, hdat);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(int style, int col, int row, int base);
        case (style)
            PAT_RAMP: return PIX_W'(base + 3 * col + 5 * row + $urandom_range(0, 3));
            PAT_STEP: return (((col / 2) + row) % 2 != 0) ? 8'hFF : 8'h00;
            default:  return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue one frame; a short stop_at leaves the frame unfinished with no drain
    task automatic queue_frame(int fw, int fh, int stop_at);
        int style, base, n;
        style = $urandom_range(PAT_NOISE, PAT_STEP);
        base  = $urandom_range(0, 255);
        for (n = 0; n < stop_at; n++)
        begin
            // occasional premature flush
            if ($urandom_range(0, 31) == 0)
                push_word(KIND_FLUSH, PIX_W'($urandom_range(0, 255)));
            push_word(KIND_PIXEL, pick_pixel(style, n % fw, n / fw, base));
            pixels_sent++;
        end
        if (stop_at == fw * fh)
        begin
            // drain with flush words, a few surplus pixels among them
            for (n = 0; n <= fw; n++)
                push_word(($urandom_range(0, 6) == 0) ? KIND_PIXEL : KIND_FLUSH,
                          PIX_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int fw, fh, nframes, roll;
        logic [CFG_DATA_W-1:0] wdat, hdat;

        // predictor reset state
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            above_line[i] = '0;
            prev_line[i]  = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        col_in  = 0;
        row_in  = 0;
        col_out = 0;
        row_out = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // smallest image, vertical step edge saturates; premature flush and surplus pixel
        set_geometry(3, 3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                if (r == 1 && c == 2)
                    push_word(KIND_FLUSH, 8'hFF);
                push_word(KIND_PIXEL, (c == 2) ? 8'hFF : 8'h00);
                pixels_sent++;
            end
        push_word(KIND_FLUSH, 8'h00);
        push_word(KIND_FLUSH, 8'h55);
        push_word(KIND_PIXEL, 8'hAA);
        push_word(KIND_FLUSH, 8'h00);

        // out-of-range geometry clamps to 3x3; negative gradient, no saturation
        set_geometry(1, 0);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                push_word(KIND_PIXEL, (r == 2) ? 8'd0 : PIX_W'(30 - 10 * c));
                pixels_sent++;
            end
        repeat (4) push_word(KIND_FLUSH, 8'h00);

        // random geometries, mostly small, with back-to-back frames
        while (pixels_sent < RANDOM_PIXELS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                wdat = $urandom_range(3, 12);
            else if (roll < 85)
                wdat = $urandom_range(13, 40);
            else if (roll < 93)
                wdat = $urandom_range(0, 2);
            else
                wdat = $urandom_range(1025, 4095);
            roll = $urandom_range(0, 99);
            if (roll < 75)
                hdat = $urandom_range(3, 8);
            else if (roll < 85)
                hdat = $urandom_range(0, 2);
            else
                hdat = $urandom_range(9, 20);
            fw = clamp_width(wdat[WIDTH_REG_W-1:0]);
            nframes = $urandom_range(1, 3);
            // keep wide images short
            if (fw > 40)
            begin
                hdat = $urandom_range(0, 3);
                nframes = 1;
            end
            fh = clamp_height(hdat);
            // keep larger images to a single frame
            if (fw * fh > 200)
                nframes = 1;
            src_steady  = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            set_geometry(wdat, hdat);
            if (fw > 40)
            begin
                // wide lines: part of a frame only, leaving live counters behind
                queue_frame(fw, fh, $urandom_range(1, WIDE_PIXELS));
            end
            else
            begin
                repeat (nframes) queue_frame(fw, fh, fw * fh);
                // sometimes stop mid-frame so the next geometry lands on live counters
                if ($urandom_range(0, 9) == 0)
                    queue_frame(fw, fh, $urandom_range(1, fw * fh - 1));
            end
        end

        // register extremes: widest line and tallest image, each a partial frame
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        set_geometry(LINE_DEPTH, 3);
        queue_frame(LINE_DEPTH, 3, EXTREME_PIXELS);
        set_geometry(3, 4095);
        queue_frame(3, 4095, EXTREME_PIXELS);

        wait_quiet();
        if (mag_pending.size() != 0)
            report_mismatch("results never delivered", 0, mag_pending.size());

        $display("Covered %0d input words (%0d pixels) over %0d register writes",
                 words_accepted, pixels_sent, reg_writes);
        $display("Checked %0d magnitudes, %0d frames closed, %0d mismatches",
                 results_checked, frames_closed, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
